@@ rtl/ffca_pkg.sv @@
// Package for the first-fit contiguous allocator: sizes, status codes, FSM states.
// No dependencies.
package ffca_pkg;

    localparam int MEM_UNITS = 1024;
    localparam int MAX_JOBS  = 64;
    localparam int UA_W      = $clog2(MEM_UNITS);
    localparam int UC_W      = $clog2(MEM_UNITS + 1);
    localparam int JA_W      = $clog2(MAX_JOBS);
    localparam int ID_W      = 8;
    localparam int ST_W      = 3;
    localparam int TBL_W     = ID_W + UA_W + UC_W;

    localparam logic [ST_W-1:0] ST_PLACED  = 3'd0;
    localparam logic [ST_W-1:0] ST_SHORT   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOHOLE  = 3'd2;
    localparam logic [ST_W-1:0] ST_FREED   = 3'd3;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd5;

    localparam logic OP_ALLOC = 1'b0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_MARK,
        S_DEAL_RD,
        S_DEAL_CHK,
        S_DEAL_CLR,
        S_OUT
    } t_state;

endpackage

@@ rtl/first_fit_contiguous_allocator.sv @@
// First-fit contiguous allocator, top level. Uses ffca_pkg and ffca_ram.
// Sequence: after reset a clearing pass zeroes all 1024 units of the owner map; no beat is
// accepted meanwhile. Allocate: a check of size, capacity and table slot (it also
// issues the first map read), a map scan (one unit per cycle through the map read
// port), marking of the placed units one by one, then loading of the result.
// Deallocate: a read state and a check state per table entry (64 entries), a clear of each
// freed unit in turn, then loading of the result. Zero id: loading of the result only.
// One request at a time; the result beat is held in an output register until taken.
module first_fit_contiguous_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_opcode,
    input  logic [7:0]                  i_job_id,
    input  logic [10:0]                 i_job_units,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_status,
    output logic [9:0]                  o_start_unit,
    output logic [10:0]                 o_units_in_use
);

    ffca_pkg::t_state r_state, n_state;

    // request registers
    logic [ffca_pkg::ID_W-1:0]    r_id;
    logic [ffca_pkg::UC_W-1:0]    r_units;
    logic [ffca_pkg::UC_W-1:0]    r_used;
    logic [ffca_pkg::UC_W-1:0]    r_cnt;      // map sweep position, one wider
    logic [ffca_pkg::UC_W-1:0]    r_run;
    logic [ffca_pkg::UA_W-1:0]    r_first;
    logic [ffca_pkg::UC_W-1:0]    r_left;     // units left to mark or clear
    logic [ffca_pkg::JA_W:0]      r_ent;      // table sweep position
    logic [ffca_pkg::JA_W-1:0]    r_slot;
    logic [ffca_pkg::MAX_JOBS-1:0] r_evalid;
    logic [ffca_pkg::ST_W-1:0]    r_status;
    logic [ffca_pkg::UA_W-1:0]    r_start;
    logic                         r_ovalid;

    // memories
    logic                         map_we;
    logic [ffca_pkg::UA_W-1:0]    map_waddr, map_raddr;
    logic [ffca_pkg::ID_W-1:0]    map_wdata, map_rdata;
    logic                         tbl_we;
    logic [ffca_pkg::TBL_W-1:0]   tbl_wdata, tbl_rdata;
    logic [ffca_pkg::JA_W-1:0]    tbl_raddr;

    ffca_ram #(.WIDTH(ffca_pkg::ID_W), .DEPTH(ffca_pkg::MEM_UNITS)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(map_raddr), .o_rdata(map_rdata)
    );

    ffca_ram #(.WIDTH(ffca_pkg::TBL_W), .DEPTH(ffca_pkg::MAX_JOBS)) u_tbl (
        .i_clk(i_clk), .i_we(tbl_we), .i_waddr(r_slot), .i_wdata(tbl_wdata),
        .i_raddr(tbl_raddr), .o_rdata(tbl_rdata)
    );

    // decoded table read
    logic [ffca_pkg::ID_W-1:0] rd_id;
    logic [ffca_pkg::UA_W-1:0] rd_start;
    logic [ffca_pkg::UC_W-1:0] rd_units;
    assign {rd_id, rd_start, rd_units} = tbl_rdata;

    // lowest free table entry
    logic                      free_found;
    logic [ffca_pkg::JA_W-1:0] free_slot;
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int k = ffca_pkg::MAX_JOBS - 1; k >= 0; k--) begin
            if (!r_evalid[k]) begin
                free_found = 1'b1;
                free_slot  = ffca_pkg::JA_W'(k);
            end
        end
    end

    logic accept_in;
    assign accept_in = i_valid && !o_stall;
    assign o_stall   = (r_state != ffca_pkg::S_IDLE);

    logic [ffca_pkg::UC_W:0] sum_used;
    assign sum_used = {1'b0, r_used} + {1'b0, r_units};

    logic over_cap;
    assign over_cap = (sum_used > (ffca_pkg::UC_W+1)'(ffca_pkg::MEM_UNITS));

    logic [ffca_pkg::UC_W-1:0] run_nx;
    assign run_nx = (map_rdata == '0) ? r_run + 1'b1 : '0;

    logic [ffca_pkg::UA_W-1:0] cur_unit;
    assign cur_unit = r_cnt[ffca_pkg::UA_W-1:0] - 1'b1;

    // start of the job being marked; r_first sits on its last unit at the final mark
    logic [ffca_pkg::UA_W-1:0] place_start;
    assign place_start = r_first - ffca_pkg::UA_W'(r_units) + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffca_pkg::S_CLEAR:
                if (r_cnt == ffca_pkg::UC_W'(ffca_pkg::MEM_UNITS - 1)) n_state = ffca_pkg::S_IDLE;
            ffca_pkg::S_IDLE:
                if (accept_in) begin
                    if (i_job_id == '0) n_state = ffca_pkg::S_OUT;
                    else if (i_opcode == ffca_pkg::OP_ALLOC) n_state = ffca_pkg::S_SCAN_RD;
                    else n_state = ffca_pkg::S_DEAL_RD;
                end
            ffca_pkg::S_SCAN_RD: begin
                if (r_units == '0 || over_cap || !free_found)
                    n_state = ffca_pkg::S_OUT;
                else n_state = ffca_pkg::S_SCAN;
            end
            ffca_pkg::S_SCAN: begin
                if (run_nx == r_units) n_state = ffca_pkg::S_MARK;
                else if (r_cnt == ffca_pkg::UC_W'(ffca_pkg::MEM_UNITS)) n_state = ffca_pkg::S_OUT;
            end
            ffca_pkg::S_MARK:
                if (r_left == ffca_pkg::UC_W'(1)) n_state = ffca_pkg::S_OUT;
            ffca_pkg::S_DEAL_RD:
                n_state = ffca_pkg::S_DEAL_CHK;
            ffca_pkg::S_DEAL_CHK: begin
                if (r_evalid[r_slot] && rd_id == r_id && rd_units != '0)
                    n_state = ffca_pkg::S_DEAL_CLR;
                else if (r_ent == (ffca_pkg::JA_W+1)'(ffca_pkg::MAX_JOBS)) n_state = ffca_pkg::S_OUT;
                else n_state = ffca_pkg::S_DEAL_RD;
            end
            ffca_pkg::S_DEAL_CLR: begin
                if (r_left == ffca_pkg::UC_W'(1) || r_first == '1) begin
                    if (r_ent == (ffca_pkg::JA_W+1)'(ffca_pkg::MAX_JOBS)) n_state = ffca_pkg::S_OUT;
                    else n_state = ffca_pkg::S_DEAL_RD;
                end
            end
            ffca_pkg::S_OUT:
                if (!r_ovalid) n_state = ffca_pkg::S_IDLE;
            default: n_state = ffca_pkg::S_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_first;
        map_wdata = '0;
        map_raddr = r_cnt[ffca_pkg::UA_W-1:0];
        tbl_we    = 1'b0;
        tbl_wdata = {r_id, place_start, r_units};
        tbl_raddr = r_ent[ffca_pkg::JA_W-1:0];
        unique case (r_state)
            ffca_pkg::S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_cnt[ffca_pkg::UA_W-1:0];
            end
            ffca_pkg::S_MARK: begin
                map_we    = 1'b1;
                map_wdata = r_id;
                tbl_we    = (r_left == ffca_pkg::UC_W'(1));
            end
            ffca_pkg::S_DEAL_CLR: map_we = 1'b1;
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffca_pkg::S_CLEAR;
            r_cnt    <= '0;
            r_used   <= '0;
            r_evalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                ffca_pkg::S_CLEAR: r_cnt <= r_cnt + 1'b1;
                ffca_pkg::S_IDLE: if (accept_in) begin
                    r_id     <= i_job_id;
                    r_units  <= i_job_units;
                    r_cnt    <= '0;
                    r_run    <= '0;
                    r_ent    <= '0;
                    r_start  <= '0;
                    r_status <= ffca_pkg::ST_UNKNOWN;
                end
                ffca_pkg::S_SCAN_RD: begin
                    r_slot <= free_slot;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_units == '0) r_status <= ffca_pkg::ST_NOHOLE;
                    else if (over_cap) r_status <= ffca_pkg::ST_SHORT;
                    else if (!free_found) r_status <= ffca_pkg::ST_FULL;
                    else r_status <= ffca_pkg::ST_NOHOLE;
                end
                ffca_pkg::S_SCAN: begin
                    r_run <= run_nx;
                    r_cnt <= r_cnt + 1'b1;
                    if (run_nx == r_units) begin
                        r_first <= cur_unit - ffca_pkg::UA_W'(r_units) + 1'b1;
                        r_left  <= r_units;
                    end
                end
                ffca_pkg::S_MARK: begin
                    r_first <= r_first + 1'b1;
                    r_left  <= r_left - 1'b1;
                    if (r_left == ffca_pkg::UC_W'(1)) begin
                        r_evalid[r_slot] <= 1'b1;
                        r_used   <= sum_used[ffca_pkg::UC_W-1:0];
                        r_status <= ffca_pkg::ST_PLACED;
                        r_start  <= place_start;
                    end
                end
                ffca_pkg::S_DEAL_RD: begin
                    r_slot <= r_ent[ffca_pkg::JA_W-1:0];
                    r_ent  <= r_ent + 1'b1;
                end
                ffca_pkg::S_DEAL_CHK: begin
                    if (r_evalid[r_slot] && rd_id == r_id) begin
                        r_evalid[r_slot] <= 1'b0;
                        r_status <= ffca_pkg::ST_FREED;
                        r_used   <= (r_used >= rd_units) ? r_used - rd_units : '0;
                        r_first  <= rd_start;
                        r_left   <= rd_units;
                    end
                end
                ffca_pkg::S_DEAL_CLR: begin
                    r_first <= r_first + 1'b1;
                    r_left  <= r_left - 1'b1;
                end
                ffca_pkg::S_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    o_status <= r_status;
                    o_start_unit <= r_start;
                    o_units_in_use <= r_used;
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovalid;

    // a placed job never pushes the total past capacity
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= ffca_pkg::MEM_UNITS)
        else $error("units in use above capacity");
    // no new request while the clearing pass runs
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ffca_pkg::S_CLEAR |-> o_stall)
        else $error("request taken during clear");
    // the last marking cycle leaves the job's table entry valid
    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffca_pkg::S_MARK && r_left == ffca_pkg::UC_W'(1)) |=> r_evalid[r_slot])
        else $error("table entry not set after placement");

endmodule

@@ rtl/ffca_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
